FILE: sv/dcd_pkg.sv
// Package for the display command decoder.
// Holds opcodes, action codes and the state and result types; no dependencies.
`default_nettype none
package dcd_pkg;

  localparam logic [7:0] OP_POSITION = 8'd1;
  localparam logic [7:0] OP_COLOR    = 8'd2;
  localparam logic [7:0] OP_PIXEL    = 8'd3;
  localparam logic [7:0] OP_RECT     = 8'd4;
  localparam logic [7:0] OP_TEXDRAW  = 8'd5;
  localparam logic [7:0] OP_TEXLOAD  = 8'd6;
  localparam logic [7:0] OP_VERTEX2  = 8'd7;
  localparam logic [7:0] OP_VERTEX3  = 8'd8;
  localparam logic [7:0] OP_TRIANGLE = 8'd9;
  localparam logic [7:0] OP_REFRESH  = 8'd42;

  localparam logic [2:0] ACT_RECT     = 3'd0;
  localparam logic [2:0] ACT_TEXDRAW  = 3'd1;
  localparam logic [2:0] ACT_TEXPIXEL = 3'd2;
  localparam logic [2:0] ACT_TRIANGLE = 3'd3;
  localparam logic [2:0] ACT_REFRESH  = 3'd4;

  localparam logic [7:0] ALPHA_SOLID = 8'hFF;

  typedef struct packed {
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  v2_x;
    logic [7:0]  v2_y;
    logic [7:0]  v3_x;
    logic [7:0]  v3_y;
    logic [23:0] color;
    logic        loading;
    logic [23:0] load_tex;
    logic [15:0] pix_count;
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  first_x;
    logic [7:0]  first_y;
    logic [7:0]  second_x;
    logic [7:0]  second_y;
    logic [7:0]  third_x;
    logic [7:0]  third_y;
    logic [31:0] color_rgba;
    logic [23:0] texture_number;
    logic [15:0] pixel_index;
    logic        last_pixel;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/display_command_decoder.sv
// Top level of the display command decoder: input register, state, result register.
// Depends on dcd_pkg and dcd_decode.
//
// Usage: command words enter on in_valid/in_stall/in_command_word; a transfer
// happens at a rising edge with valid high and stall low. Draw primitives leave
// on out_valid/out_stall and the out_ field ports under the same rule.
// A word is held in an input register, decoded against the kept position,
// vertices, color and texture-load state, and the primitive, if any, is
// written to the result register once that register can load. One word is
// taken every cycle while in_stall is low; the throughput is set by the single
// decode stage between the two registers. Words that cause no primitive
// (zero words, state updates, unknown opcodes) produce no output transfer;
// only the state updates among them change the kept state.
// While the receiver stalls, the result register holds its value and the input
// register still fills, so one more word is taken before in_stall rises.
// Synchronous reset clears all kept state, ends any texture load and empties
// both registers.
`default_nettype none
module display_command_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_command_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_action,
  output logic [7:0]       out_first_x,
  output logic [7:0]       out_first_y,
  output logic [7:0]       out_second_x,
  output logic [7:0]       out_second_y,
  output logic [7:0]       out_third_x,
  output logic [7:0]       out_third_y,
  output logic [31:0]      out_color_rgba,
  output logic [23:0]      out_texture_number,
  output logic [15:0]      out_pixel_index,
  output logic             out_last_pixel
);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [31:0]      s1_word_r;
  dcd_pkg::state_t  st_r;
  dcd_pkg::state_t  st_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  dcd_pkg::result_t res_r;
  dcd_pkg::result_t dec_res;
  logic             dec_has_result;
  logic             out_load;
  logic             in_take;
  logic             step;

  dcd_decode u_decode (
    .word       (s1_word_r),
    .st         (st_r),
    .has_result (dec_has_result),
    .res        (dec_res),
    .st_nxt     (st_nxt)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;
  assign step     = s1_valid_r && out_load;

  assign s1_valid_nxt  = in_take ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? (s1_valid_r && dec_has_result) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_command_word;
    end
    if (step) begin
      res_r <= dec_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = res_r.action;
  assign out_first_x        = res_r.first_x;
  assign out_first_y        = res_r.first_y;
  assign out_second_x       = res_r.second_x;
  assign out_second_y       = res_r.second_y;
  assign out_third_x        = res_r.third_x;
  assign out_third_y        = res_r.third_y;
  assign out_color_rgba     = res_r.color_rgba;
  assign out_texture_number = res_r.texture_number;
  assign out_pixel_index    = res_r.pixel_index;
  assign out_last_pixel     = res_r.last_pixel;

endmodule
`default_nettype wire

FILE: sv/dcd_decode.sv
// Combinational decode of one command word against the current decoder state.
// Depends on dcd_pkg for opcodes, action codes, state_t and result_t.
`default_nettype none
module dcd_decode (
  input  wire logic [31:0]     word,
  input  wire dcd_pkg::state_t st,
  output logic                 has_result,
  output dcd_pkg::result_t     res,
  output dcd_pkg::state_t      st_nxt
);

  logic [7:0]  op;
  logic [7:0]  a1;
  logic [7:0]  a2;
  logic [23:0] hi24;
  logic [15:0] area;
  logic [16:0] idx_inc;
  logic        last;

  assign op      = word[7:0];
  assign a1      = word[15:8];
  assign a2      = word[23:16];
  assign hi24    = word[31:8];
  assign area    = st.pos_x * st.pos_y;
  assign idx_inc = {1'b0, st.pix_count} + 17'd1;
  assign last    = idx_inc >= {1'b0, area};

  always_comb begin
    has_result = 1'b0;
    res        = '0;
    st_nxt     = st;
    if (word == 32'd0) begin
      has_result = 1'b0;
    end else if (st.loading) begin
      has_result         = 1'b1;
      res.action         = dcd_pkg::ACT_TEXPIXEL;
      res.color_rgba     = word;
      res.texture_number = st.load_tex;
      res.pixel_index    = st.pix_count;
      res.last_pixel     = last;
      st_nxt.pix_count   = idx_inc[15:0];
      if (last) begin
        st_nxt.loading = 1'b0;
      end
    end else begin
      case (op)
        dcd_pkg::OP_POSITION: begin
          st_nxt.pos_x = a1;
          st_nxt.pos_y = a2;
        end
        dcd_pkg::OP_COLOR: begin
          st_nxt.color = hi24;
        end
        dcd_pkg::OP_PIXEL: begin
          has_result     = 1'b1;
          res.action     = dcd_pkg::ACT_RECT;
          res.first_x    = a1;
          res.first_y    = a2;
          res.second_x   = 8'd1;
          res.second_y   = 8'd1;
          res.color_rgba = {dcd_pkg::ALPHA_SOLID, st.color};
        end
        dcd_pkg::OP_RECT: begin
          has_result     = 1'b1;
          res.action     = dcd_pkg::ACT_RECT;
          res.first_x    = st.pos_x;
          res.first_y    = st.pos_y;
          res.second_x   = a1;
          res.second_y   = a2;
          res.color_rgba = {dcd_pkg::ALPHA_SOLID, st.color};
        end
        dcd_pkg::OP_TEXDRAW: begin
          has_result         = 1'b1;
          res.action         = dcd_pkg::ACT_TEXDRAW;
          res.first_x        = st.pos_x;
          res.first_y        = st.pos_y;
          res.texture_number = hi24;
        end
        dcd_pkg::OP_TEXLOAD: begin
          if (area != 16'd0) begin
            st_nxt.loading   = 1'b1;
            st_nxt.load_tex  = hi24;
            st_nxt.pix_count = 16'd0;
          end
        end
        dcd_pkg::OP_VERTEX2: begin
          st_nxt.v2_x = a1;
          st_nxt.v2_y = a2;
        end
        dcd_pkg::OP_VERTEX3: begin
          st_nxt.v3_x = a1;
          st_nxt.v3_y = a2;
        end
        dcd_pkg::OP_TRIANGLE: begin
          has_result     = 1'b1;
          res.action     = dcd_pkg::ACT_TRIANGLE;
          res.first_x    = st.pos_x;
          res.first_y    = st.pos_y;
          res.second_x   = st.v2_x;
          res.second_y   = st.v2_y;
          res.third_x    = st.v3_x;
          res.third_y    = st.v3_y;
          res.color_rgba = {dcd_pkg::ALPHA_SOLID, hi24};
        end
        dcd_pkg::OP_REFRESH: begin
          has_result = 1'b1;
          res.action = dcd_pkg::ACT_REFRESH;
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/dcd_checker.sv
// Port-level checker for the display command decoder, bound to the top level.
// Depends on dcd_pkg for action codes.
`default_nettype none
module dcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_action,
  input wire logic [7:0]  out_first_x,
  input wire logic [7:0]  out_first_y,
  input wire logic [7:0]  out_second_x,
  input wire logic [7:0]  out_second_y,
  input wire logic [7:0]  out_third_x,
  input wire logic [7:0]  out_third_y,
  input wire logic [31:0] out_color_rgba,
  input wire logic [23:0] out_texture_number,
  input wire logic [15:0] out_pixel_index,
  input wire logic        out_last_pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action)
      && $stable(out_color_rgba) && $stable(out_pixel_index))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_refresh_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == dcd_pkg::ACT_REFRESH |->
      out_first_x == 8'd0 && out_first_y == 8'd0 && out_second_x == 8'd0
      && out_second_y == 8'd0 && out_third_x == 8'd0 && out_third_y == 8'd0
      && out_color_rgba == 32'd0 && out_texture_number == 24'd0
      && out_pixel_index == 16'd0 && !out_last_pixel)
    else $error("refresh carries nonzero fields");

  a_texpixel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == dcd_pkg::ACT_TEXPIXEL |-> out_color_rgba != 32'd0)
    else $error("texture pixel from a zero word");

  a_solid_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == dcd_pkg::ACT_RECT
      || out_action == dcd_pkg::ACT_TRIANGLE) |-> out_color_rgba[31:24] == 8'hFF)
    else $error("solid draw without full alpha");

endmodule

bind display_command_decoder dcd_checker u_dcd_checker (.*);
`default_nettype wire
